FILE: hdl/apcf_pkg.sv
// apcf_pkg: shared types, command codes and frame constants for the
// audio player command framer; no dependencies
package apcf_pkg;

  localparam int unsigned KindW    = 4;
  localparam int unsigned VolW     = 5;
  localparam int unsigned FrameLen = 10;
  localparam int unsigned ByteIdxW = $clog2(FrameLen);
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [VolW-1:0] VolMax     = 5'd30;
  localparam logic [VolW-1:0] VolStep    = 5'd3;
  localparam logic [VolW-1:0] VolDefault = 5'd15;
  localparam logic [7:0]      EqMax      = 8'd5;

  // fixed frame bytes
  localparam logic [7:0] ByteStart   = 8'h7E;
  localparam logic [7:0] ByteVersion = 8'hFF;
  localparam logic [7:0] ByteLength  = 8'h06;
  localparam logic [7:0] ByteNoFb    = 8'h00;
  localparam logic [7:0] ByteEnd     = 8'hEF;

  // command codes on the wire
  localparam logic [7:0] CmdPlay   = 8'h0D;
  localparam logic [7:0] CmdPause  = 8'h0E;
  localparam logic [7:0] CmdStop   = 8'h16;
  localparam logic [7:0] CmdNext   = 8'h01;
  localparam logic [7:0] CmdPrev   = 8'h02;
  localparam logic [7:0] CmdVolume = 8'h06;
  localparam logic [7:0] CmdEq     = 8'h07;
  localparam logic [7:0] CmdFolder = 8'h0F;
  localparam logic [7:0] CmdTrack  = 8'h03;
  localparam logic [7:0] CmdSource = 8'h09;

  localparam logic [15:0] ParamSourceSd = 16'h0002;

  typedef enum logic [KindW-1:0] {
    KIND_PLAY    = 4'd0,
    KIND_PAUSE   = 4'd1,
    KIND_STOP    = 4'd2,
    KIND_NEXT    = 4'd3,
    KIND_PREV    = 4'd4,
    KIND_SET_VOL = 4'd5,
    KIND_VOL_UP  = 4'd6,
    KIND_VOL_DN  = 4'd7,
    KIND_EQ      = 4'd8,
    KIND_FOLDER  = 4'd9,
    KIND_TRACK   = 4'd10,
    KIND_INIT    = 4'd11
  } kind_e;

  // init sequence steps
  typedef enum logic [1:0] {
    INIT_SOURCE = 2'd0,
    INIT_VOLUME = 2'd1,
    INIT_EQ     = 2'd2
  } init_step_e;

  // byte positions within a frame
  typedef enum logic [ByteIdxW-1:0] {
    POS_START   = 4'd0,
    POS_VERSION = 4'd1,
    POS_LENGTH  = 4'd2,
    POS_CMD     = 4'd3,
    POS_FB      = 4'd4,
    POS_PAR_HI  = 4'd5,
    POS_PAR_LO  = 4'd6,
    POS_CHK_HI  = 4'd7,
    POS_CHK_LO  = 4'd8,
    POS_END     = 4'd9
  } byte_pos_e;

  // one frame to be sent
  typedef struct packed {
    logic [7:0]      cmd;
    logic [15:0]     param;
    logic [15:0]     chk;
    logic            final_frame;
    logic [VolW-1:0] vol;
  } desc_t;

  function automatic logic [15:0] frame_chk(input logic [7:0] cmd, input logic [15:0] param);
    logic [15:0] sum;
    sum = {8'd0, ByteVersion} + {8'd0, ByteLength} + {8'd0, cmd} + {8'd0, ByteNoFb}
        + {8'd0, param[15:8]} + {8'd0, param[7:0]};
    return 16'd0 - sum;
  endfunction

endpackage

FILE: hdl/apcf_front.sv
// apcf_front: accepts commands, keeps the stored volume and turns each
// command of kinds 0 to 11 into one or three frame descriptors; uses apcf_pkg
module apcf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [3:0]           kind_i,
  input  logic [7:0]           level_i,
  input  logic [7:0]           folder_i,
  input  logic [7:0]           file_i,
  input  logic [15:0]          track_i,
  output logic                 push_o,
  output apcf_pkg::desc_t      push_desc_o,
  input  logic                 q_full_i,
  output logic [apcf_pkg::VolW-1:0] cur_vol_o
);
  import apcf_pkg::*;

  logic            pend_valid_q, pend_valid_d;
  logic            pend_init_q, pend_init_d;
  logic [7:0]      pend_cmd_q, pend_cmd_d;
  logic [15:0]     pend_param_q, pend_param_d;
  logic [VolW-1:0] pend_vol_q, pend_vol_d;
  init_step_e      step_q, step_d;
  logic [VolW-1:0] vol_q, vol_d;

  kind_e           kind;
  logic            kind_ok;
  logic            accept;
  logic            item_done;
  logic [7:0]      cmd_sel;
  logic [15:0]     par_sel;
  logic            fin_sel;

  assign kind    = kind_e'(kind_i);
  assign kind_ok = (kind_i <= KIND_INIT);

  // new volume and frame content for the incoming command
  always_comb begin
    vol_d        = vol_q;
    pend_cmd_d   = CmdPlay;
    pend_param_d = 16'd0;
    unique case (kind)
      KIND_PLAY:  pend_cmd_d = CmdPlay;
      KIND_PAUSE: pend_cmd_d = CmdPause;
      KIND_STOP:  pend_cmd_d = CmdStop;
      KIND_NEXT:  pend_cmd_d = CmdNext;
      KIND_PREV:  pend_cmd_d = CmdPrev;
      KIND_SET_VOL: begin
        vol_d      = (level_i > {3'd0, VolMax}) ? VolMax : level_i[VolW-1:0];
        pend_cmd_d = CmdVolume;
      end
      KIND_VOL_UP: begin
        vol_d      = (vol_q >= VolMax - VolStep) ? VolMax : vol_q + VolStep;
        pend_cmd_d = CmdVolume;
      end
      KIND_VOL_DN: begin
        vol_d      = (vol_q >= VolStep) ? vol_q - VolStep : '0;
        pend_cmd_d = CmdVolume;
      end
      KIND_EQ: begin
        pend_cmd_d   = CmdEq;
        pend_param_d = (level_i > EqMax) ? 16'd0 : {8'd0, level_i};
      end
      KIND_FOLDER: begin
        pend_cmd_d   = CmdFolder;
        pend_param_d = {folder_i, file_i};
      end
      KIND_TRACK: begin
        pend_cmd_d   = CmdTrack;
        pend_param_d = track_i;
      end
      KIND_INIT: begin
        vol_d      = VolDefault;
        pend_cmd_d = CmdSource;
      end
      default: vol_d = vol_q;
    endcase
    if (kind == KIND_SET_VOL || kind == KIND_VOL_UP || kind == KIND_VOL_DN) begin
      pend_param_d = {{(16-VolW){1'b0}}, vol_d};
    end
  end

  // descriptor for the held command
  always_comb begin
    cmd_sel = pend_cmd_q;
    par_sel = pend_param_q;
    fin_sel = 1'b1;
    if (pend_init_q) begin
      unique case (step_q)
        INIT_SOURCE: begin
          cmd_sel = CmdSource;
          par_sel = ParamSourceSd;
          fin_sel = 1'b0;
        end
        INIT_VOLUME: begin
          cmd_sel = CmdVolume;
          par_sel = {{(16-VolW){1'b0}}, pend_vol_q};
          fin_sel = 1'b0;
        end
        INIT_EQ: begin
          cmd_sel = CmdEq;
          par_sel = 16'd0;
          fin_sel = 1'b1;
        end
        default: begin
          cmd_sel = CmdEq;
          par_sel = 16'd0;
          fin_sel = 1'b1;
        end
      endcase
    end
  end

  assign push_o                  = pend_valid_q && !q_full_i;
  assign push_desc_o.cmd         = cmd_sel;
  assign push_desc_o.param       = par_sel;
  assign push_desc_o.chk         = frame_chk(cmd_sel, par_sel);
  assign push_desc_o.final_frame = fin_sel;
  assign push_desc_o.vol         = pend_vol_q;

  assign item_done  = push_o && (!pend_init_q || step_q == INIT_EQ);
  assign in_ready_o = !pend_valid_q || item_done;
  assign accept     = in_valid_i && in_ready_o;
  assign cur_vol_o  = vol_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_init_d  = pend_init_q;
    pend_vol_d   = pend_vol_q;
    step_d       = step_q;
    if (accept && kind_ok) begin
      pend_valid_d = 1'b1;
      pend_init_d  = (kind == KIND_INIT);
      pend_vol_d   = vol_d;
      step_d       = INIT_SOURCE;
    end else if (item_done) begin
      pend_valid_d = 1'b0;
    end else if (push_o) begin
      step_d = init_step_e'(step_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_init_q  <= 1'b0;
      step_q       <= INIT_SOURCE;
      vol_q        <= VolDefault;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_init_q  <= pend_init_d;
      step_q       <= step_d;
      if (accept && kind_ok) begin
        vol_q <= vol_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_vol_q <= pend_vol_d;
    if (accept && kind_ok) begin
      pend_cmd_q   <= pend_cmd_d;
      pend_param_q <= pend_param_d;
    end
  end

endmodule

FILE: hdl/apcf_queue.sv
// apcf_queue: two-entry descriptor queue between front and back end;
// uses apcf_pkg
module apcf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  apcf_pkg::desc_t push_desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output apcf_pkg::desc_t head_o
);
  import apcf_pkg::*;

  desc_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

FILE: hdl/apcf_back.sv
// apcf_back: serialises the head descriptor into ten frame bytes into a
// registered output stage; uses apcf_pkg
module apcf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  apcf_pkg::desc_t      head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic [apcf_pkg::VolW-1:0] out_vol_o
);
  import apcf_pkg::*;

  byte_pos_e       pos_q, pos_d;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic [VolW-1:0] vol_q;
  logic            load;

  assign load  = (!valid_q || out_ready_i) && !empty_i;
  assign pop_o = load && (pos_q == POS_END);

  always_comb begin
    unique case (pos_q)
      POS_START:   byte_d = ByteStart;
      POS_VERSION: byte_d = ByteVersion;
      POS_LENGTH:  byte_d = ByteLength;
      POS_CMD:     byte_d = head_i.cmd;
      POS_FB:      byte_d = ByteNoFb;
      POS_PAR_HI:  byte_d = head_i.param[15:8];
      POS_PAR_LO:  byte_d = head_i.param[7:0];
      POS_CHK_HI:  byte_d = head_i.chk[15:8];
      POS_CHK_LO:  byte_d = head_i.chk[7:0];
      POS_END:     byte_d = ByteEnd;
      default:     byte_d = ByteEnd;
    endcase
    last_d = head_i.final_frame && (pos_q == POS_END);
  end

  always_comb begin
    pos_d   = pos_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      pos_d   = (pos_q == POS_END) ? POS_START : byte_pos_e'(pos_q + 1'b1);
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_START;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= last_d;
      vol_q  <= head_i.vol;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_vol_o   = vol_q;

endmodule

FILE: hdl/audio_player_command_framer.sv
// audio_player_command_framer: top level, front end, descriptor queue and
// byte serialiser; uses apcf_pkg, apcf_front, apcf_queue, apcf_back
//
// Each command beat becomes a ten-byte player frame (0x7E, 0xFF, 0x06, command,
// 0x00, parameter high/low, checksum high/low, 0xEF), sent as one output beat
// per byte; initialise sends three frames (30 beats) and only the very last
// byte of a command carries tlast. Output runs at one byte per cycle while
// tready is high and frames are queued, paced by the byte serialiser in the
// back end. The front end holds one command and a two-frame queue sits
// between it and the serialiser, so a new command is taken
// while earlier frames are still being sent; kinds 12 to 15 are taken and
// dropped. The stored volume (reset 15, range 0..30) rides on every beat.
module audio_player_command_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // kind[3:0], level[11:4], folder[19:12], file[27:20], track[43:28], zero pad
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // frame_byte[7:0], volume[12:8], zero pad
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);
  import apcf_pkg::*;

  logic            push;
  desc_t           push_desc;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  desc_t           head;
  logic [7:0]      out_byte;
  logic [VolW-1:0] out_vol;
  logic [VolW-1:0] cur_vol;

  apcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .kind_i      (s_axis_tdata_i[3:0]),
    .level_i     (s_axis_tdata_i[11:4]),
    .folder_i    (s_axis_tdata_i[19:12]),
    .file_i      (s_axis_tdata_i[27:20]),
    .track_i     (s_axis_tdata_i[43:28]),
    .push_o      (push),
    .push_desc_o (push_desc),
    .q_full_i    (q_full),
    .cur_vol_o   (cur_vol)
  );

  apcf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  apcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (out_byte),
    .out_last_o  (m_axis_tlast_o),
    .out_vol_o   (out_vol)
  );

  assign m_axis_tdata_o = {{(16-8-VolW){1'b0}}, out_vol, out_byte};

  a_vol_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vol <= VolMax)
    else $error("stored volume out of range");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full))
    else $error("descriptor pushed into a full queue");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_empty))
    else $error("descriptor popped from an empty queue");

  a_last_is_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (out_byte == ByteEnd))
    else $error("tlast on a byte other than the end marker");

endmodule

FILE: test/tb_audio_player_command_framer.sv
// tb_audio_player_command_framer: self-checking bench for the player command framer,
// a directed table then random commands, every output beat checked against a predictor
// depends on apcf_pkg and audio_player_command_framer
`timescale 1ns / 100ps

module tb_audio_player_command_framer;
  import apcf_pkg::*;

  localparam logic [KindW-1:0] KindSpareLo = 4'd12;
  localparam logic [KindW-1:0] KindSpareHi = 4'd15;
  localparam int unsigned NumDirected = 25;
  localparam int unsigned NumRandom   = 395;

  // one expected output beat
  typedef struct packed {
    logic [7:0]      data;
    logic            last;
    logic [VolW-1:0] vol;
  } beat_t;

  // one directed command; vol_fixed marks a volume that is known at a glance
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [7:0]       level;
    logic [7:0]       folder;
    logic [7:0]       file;
    logic [15:0]      track;
    logic             vol_fixed;
    logic [VolW-1:0]  vol;
  } cmd_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cmd_valid = 1'b0;
  logic [47:0] cmd_data = '0;
  logic        cmd_ready;
  logic        byte_valid;
  logic        byte_ready = 1'b0;
  logic [15:0] byte_data;
  logic        byte_last;

  beat_t       frame_beats_due[$];
  logic [VolW-1:0] stored_vol;
  cmd_row_t    cmd_table[NumDirected];
  bit          calm;
  int          rx_hold;
  int          mismatches;
  int          beats_checked;
  int          cmds_framed;
  int          cmds_dropped;
  int          kind_hits[16];
  bit          saw_vol_top;
  bit          saw_vol_floor;

  audio_player_command_framer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(cmd_valid),
    .s_axis_tready_o(cmd_ready),
    .s_axis_tdata_i (cmd_data),
    .m_axis_tvalid_o(byte_valid),
    .m_axis_tready_i(byte_ready),
    .m_axis_tdata_o (byte_data),
    .m_axis_tlast_o (byte_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(16_000_000);
    $display("%0t: timed out with %0d beats still due", $time, frame_beats_due.size());
    $display("tb_audio_player_command_framer: errors");
    $finish;
  end

  // ten bytes of one frame, checksum is the negated 16-bit sum of bytes 1..6
  task automatic push_frame(input logic [7:0] cmd, input logic [15:0] param,
                            input logic final_frame, input logic [VolW-1:0] vol);
    logic [15:0] chk;
    logic [7:0]  bytes[FrameLen];
    chk = 16'd0 - (16'(ByteVersion) + 16'(ByteLength) + 16'(cmd) + 16'(ByteNoFb)
                   + 16'(param[15:8]) + 16'(param[7:0]));
    bytes = '{ByteStart, ByteVersion, ByteLength, cmd, ByteNoFb,
              param[15:8], param[7:0], chk[15:8], chk[7:0], ByteEnd};
    for (int i = 0; i < FrameLen; i++)
      frame_beats_due.push_back('{bytes[i], final_frame && (i == FrameLen - 1), vol});
  endtask

  task automatic predict_frames(input cmd_row_t c);
    logic [VolW-1:0] vol;
    int              up;
    logic [7:0]      eq_mode;
    case (c.kind)
      KIND_SET_VOL: stored_vol = (c.level > 8'(VolMax)) ? VolMax : c.level[VolW-1:0];
      KIND_VOL_UP: begin
        up = int'(stored_vol) + int'(VolStep);
        if (stored_vol < VolMax) stored_vol = (up > int'(VolMax)) ? VolMax : VolW'(up);
      end
      KIND_VOL_DN: stored_vol = (stored_vol >= VolStep) ? stored_vol - VolStep : '0;
      KIND_INIT:   stored_vol = VolDefault;
      default: ;
    endcase
    vol = c.vol_fixed ? c.vol : stored_vol;
    eq_mode = (c.level > EqMax) ? 8'd0 : c.level;
    case (c.kind)
      KIND_PLAY:    push_frame(CmdPlay, 16'd0, 1'b1, vol);
      KIND_PAUSE:   push_frame(CmdPause, 16'd0, 1'b1, vol);
      KIND_STOP:    push_frame(CmdStop, 16'd0, 1'b1, vol);
      KIND_NEXT:    push_frame(CmdNext, 16'd0, 1'b1, vol);
      KIND_PREV:    push_frame(CmdPrev, 16'd0, 1'b1, vol);
      KIND_SET_VOL, KIND_VOL_UP, KIND_VOL_DN:
        push_frame(CmdVolume, 16'(stored_vol), 1'b1, vol);
      KIND_EQ:      push_frame(CmdEq, 16'(eq_mode), 1'b1, vol);
      KIND_FOLDER:  push_frame(CmdFolder, {c.folder, c.file}, 1'b1, vol);
      KIND_TRACK:   push_frame(CmdTrack, c.track, 1'b1, vol);
      KIND_INIT: begin
        push_frame(CmdSource, ParamSourceSd, 1'b0, vol);
        push_frame(CmdVolume, 16'(VolDefault), 1'b0, vol);
        push_frame(CmdEq, 16'd0, 1'b1, vol);
      end
      default: cmds_dropped++;
    endcase
    if (c.kind < KindSpareLo) cmds_framed++;
    kind_hits[c.kind]++;
    if (stored_vol == VolMax) saw_vol_top = 1'b1;
    if (stored_vol == '0) saw_vol_floor = 1'b1;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one command beat and wait for it to be taken, then idle for a random gap, which may be none
  task automatic send_command(input cmd_row_t c);
    int gap;
    @(negedge clk_i);
    cmd_valid <= 1'b1;
    cmd_data  <= {4'd0, c.track, c.file, c.folder, c.level, c.kind};
    do @(posedge clk_i); while (!cmd_ready);
    predict_frames(c);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_frames();
    @(negedge clk_i);
    cmd_valid <= 1'b0;
    while (frame_beats_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic cmd_row_t random_command();
    cmd_row_t c;
    int       r;
    c.vol_fixed = 1'b0;
    c.vol       = '0;
    c.folder    = 8'($urandom);
    c.file      = 8'($urandom);
    c.track     = 16'($urandom);
    c.level     = $urandom_range(0, 1) ? 8'($urandom_range(0, 35)) : 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 6) begin
      c.kind = KindW'($urandom_range(int'(KindSpareLo), int'(KindSpareHi)));
    end else begin
      r = $urandom_range(0, 19);
      case (r)
        12, 13: c.kind = KIND_VOL_UP;
        14, 15: c.kind = KIND_VOL_DN;
        16, 17: c.kind = KIND_SET_VOL;
        18:     c.kind = KIND_EQ;
        19:     c.kind = KIND_TRACK;
        default: c.kind = KindW'(r);
      endcase
    end
    if (c.kind == KIND_EQ && $urandom_range(0, 1)) c.level = 8'($urandom_range(0, 7));
    return c;
  endfunction

  // output side: random stalls, some long, none in the calm stretch
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_ready <= 1'b0;
    end else if (calm) begin
      byte_ready <= 1'b1;
    end else if (rx_hold > 0) begin
      byte_ready <= 1'b0;
      rx_hold--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          byte_ready <= 1'b0;
          rx_hold = $urandom_range(0, 3);
        end
        4: begin
          byte_ready <= 1'b0;
          rx_hold = $urandom_range(10, 30);
        end
        default: byte_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni && byte_valid && byte_ready) begin
      beats_checked++;
      if (frame_beats_due.size() == 0) begin
        mismatches++;
        $display("%0t: beat with nothing due: byte %h last %b vol %0d", $time,
                 byte_data[7:0], byte_last, byte_data[12:8]);
      end else begin
        want = frame_beats_due.pop_front();
        if (byte_data[7:0] !== want.data) begin
          mismatches++;
          $display("%0t: frame byte expected %h got %h", $time, want.data, byte_data[7:0]);
        end
        if (byte_last !== want.last) begin
          mismatches++;
          $display("%0t: tlast expected %b got %b", $time, want.last, byte_last);
        end
        if (byte_data[12:8] !== want.vol) begin
          mismatches++;
          $display("%0t: volume expected %0d got %0d", $time, want.vol, byte_data[12:8]);
        end
      end
    end
  end

  initial begin
    int framed_goal;
    cmd_table = '{
      '{KIND_PLAY,    8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1, 5'd15},
      '{KIND_PAUSE,   8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 5'd0},
      '{KIND_STOP,    8'hA5, 8'h5A, 8'hC3, 16'h3C3C, 1'b0, 5'd0},
      '{KIND_NEXT,    8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 5'd0},
      '{KIND_PREV,    8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 5'd0},
      '{KIND_SET_VOL, 8'd0,  8'h00, 8'h00, 16'h0000, 1'b1, 5'd0},
      '{KIND_VOL_DN,  8'd0,  8'h00, 8'h00, 16'h0000, 1'b1, 5'd0},
      '{KIND_VOL_UP,  8'd0,  8'h00, 8'h00, 16'h0000, 1'b1, 5'd3},
      '{KIND_SET_VOL, 8'd30, 8'h00, 8'h00, 16'h0000, 1'b1, 5'd30},
      '{KIND_VOL_UP,  8'd0,  8'h00, 8'h00, 16'h0000, 1'b1, 5'd30},
      '{KIND_SET_VOL, 8'd29, 8'h00, 8'h00, 16'h0000, 1'b1, 5'd29},
      '{KIND_VOL_UP,  8'd0,  8'h00, 8'h00, 16'h0000, 1'b1, 5'd30},
      '{KIND_SET_VOL, 8'd255, 8'h00, 8'h00, 16'h0000, 1'b1, 5'd30},
      '{KIND_SET_VOL, 8'd1,  8'h00, 8'h00, 16'h0000, 1'b1, 5'd1},
      '{KIND_VOL_DN,  8'd0,  8'h00, 8'h00, 16'h0000, 1'b1, 5'd0},
      '{KIND_EQ,      8'd0,  8'h00, 8'h00, 16'h0000, 1'b0, 5'd0},
      '{KIND_EQ,      8'd6,  8'h00, 8'h00, 16'h0000, 1'b0, 5'd0},
      '{KIND_EQ,      8'd255, 8'h00, 8'h00, 16'h0000, 1'b0, 5'd0},
      '{KIND_FOLDER,  8'd0,  8'h00, 8'h00, 16'h0000, 1'b0, 5'd0},
      '{KIND_FOLDER,  8'd0,  8'hFF, 8'hFF, 16'h0000, 1'b0, 5'd0},
      '{KIND_TRACK,   8'd0,  8'h00, 8'h00, 16'h0000, 1'b0, 5'd0},
      '{KIND_TRACK,   8'd0,  8'h00, 8'h00, 16'hFFFF, 1'b0, 5'd0},
      '{KIND_INIT,    8'd0,  8'h00, 8'h00, 16'h0000, 1'b1, 5'd15},
      '{KindSpareLo,  8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0, 5'd0},
      '{KindSpareHi,  8'h00, 8'h00, 8'h00, 16'h0000, 1'b0, 5'd0}
    };
    stored_vol = VolDefault;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (cmd_table[i]) send_command(cmd_table[i]);
    drain_frames();

    framed_goal = cmds_framed + NumRandom;
    while (cmds_framed < framed_goal) begin
      // a stretch with no stalls on either side
      calm = (cmds_framed >= framed_goal - 300) && (cmds_framed < framed_goal - 240);
      if (cmds_framed == framed_goal - 150) drain_frames();
      send_command(random_command());
    end
    calm = 1'b0;

    drain_frames();
    repeat (60) @(posedge clk_i);

    $display("%0d commands framed, %0d spare kinds dropped, %0d beats checked",
             cmds_framed, cmds_dropped, beats_checked);
    $display("init sent %0d times, volume reached top %b and floor %b",
             kind_hits[KIND_INIT], saw_vol_top, saw_vol_floor);
    if (mismatches == 0 && frame_beats_due.size() == 0) begin
      $display("tb_audio_player_command_framer: clean");
    end else begin
      $display("tb_audio_player_command_framer: errors");
    end
    $finish;
  end

endmodule
